### sv/fbt_pkg.sv
// Shared types, codes and the character-class function for the form body tokenizer.
// No dependencies; imported by the step logic, the top level and the checker.
package fbt_pkg;

   localparam int unsigned ByteWidth  = 8;
   localparam int unsigned RoleWidth  = 3;
   localparam int unsigned ErrWidth   = 3;
   localparam int unsigned UserWidth  = RoleWidth + 1 + ErrWidth;

   localparam logic [ByteWidth-1:0] ChEquals = 8'h3D;
   localparam logic [ByteWidth-1:0] ChAmp    = 8'h26;

   typedef enum logic [1:0] {
      PH_NAME  = 2'd0,
      PH_VALUE = 2'd1,
      PH_ERROR = 2'd2
   } phase_type;

   typedef enum logic [RoleWidth-1:0] {
      ROLE_NAME    = 3'd0,
      ROLE_EQUALS  = 3'd1,
      ROLE_VALUE   = 3'd2,
      ROLE_AMP     = 3'd3,
      ROLE_IGNORED = 3'd4
   } role_type;

   typedef enum logic [ErrWidth-1:0] {
      ERR_NONE        = 3'd0,
      ERR_NO_EQUALS   = 3'd1,
      ERR_EMPTY_NAME  = 3'd2,
      ERR_BAD_NAME    = 3'd3,
      ERR_EMPTY_VALUE = 3'd4,
      ERR_BAD_VALUE   = 3'd5
   } err_type;

   typedef struct packed {
      phase_type phase;
      logic      name_started;
      logic      name_bad;
   } tok_state_type;

   typedef struct packed {
      role_type role;
      logic     pair_done;
      err_type  error_code;
   } tok_result_type;

   // letters, digits, whitespace and the symbols - _ * ^ % $ @ !
   function automatic logic allowed_byte(input logic [ByteWidth-1:0] c);
      logic ok;
      ok = 1'b0;
      if (c >= 8'h61 && c <= 8'h7A) ok = 1'b1;
      if (c >= 8'h41 && c <= 8'h5A) ok = 1'b1;
      if (c >= 8'h30 && c <= 8'h39) ok = 1'b1;
      if (c == 8'h20 || (c >= 8'h09 && c <= 8'h0D)) ok = 1'b1;
      case (c)
         8'h2D, 8'h5F, 8'h2A, 8'h5E, 8'h25, 8'h24, 8'h40, 8'h21: ok = 1'b1;
         default: ;
      endcase
      return ok;
   endfunction

endpackage

### sv/form_body_tokenizer_unit.sv
// Each accepted req word passes the input register and then the result register to rsp.
// Throughput: one byte per cycle while the result register is empty or drains.
// A full result register blocks input only while the input register is full too: the input
// register takes words while it is empty or while the result register drains or is empty.
// Reset (synchronous, active high) empties both registers and returns the parser to the
// name phase with no name bytes seen.
module form_body_tokenizer_unit import fbt_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [ByteWidth-1:0] req_tdata,   // [7:0] data_byte
   input  logic                 req_tlast,   // last_byte
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [ByteWidth-1:0] rsp_tdata,   // [7:0] byte_out
   output logic [UserWidth-1:0] rsp_tuser,   // [2:0] role, [3] pair_done, [6:4] error_code
   output logic                 rsp_tlast    // body_end
);

   logic                 in_valid_ff;
   logic [ByteWidth-1:0] in_data_ff;
   logic                 in_last_ff;

   logic                 out_valid_ff;
   logic [ByteWidth-1:0] out_data_ff;
   logic [UserWidth-1:0] out_user_ff;
   logic                 out_last_ff;

   tok_state_type        state_ff;
   tok_state_type        state_in;
   tok_result_type       result;

   logic                 out_free;
   logic                 advance;
   logic                 take;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;
   assign take       = req_tvalid && req_tready;

   fbt_step u_step (
      .data_byte (in_data_ff),
      .last_byte (in_last_ff),
      .state_cur (state_ff),
      .state_nxt (state_in),
      .result    (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '{phase: PH_NAME, name_started: 1'b0, name_bad: 1'b0};
      end else begin
         if (take) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
            state_ff     <= state_in;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_data_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (advance) begin
         out_data_ff <= in_data_ff;
         out_user_ff <= {result.error_code, result.pair_done, result.role};
         out_last_ff <= in_last_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_user_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

### sv/fbt_step.sv
// Combinational tokenizer step: tags one byte and computes the next parse state.
// Depends on fbt_pkg for the state, role and error types and the character class.
module fbt_step import fbt_pkg::*; (
   input  logic [ByteWidth-1:0] data_byte,
   input  logic                 last_byte,
   input  tok_state_type        state_cur,
   output tok_state_type        state_nxt,
   output tok_result_type       result
);

   logic is_ok;
   logic is_eq;
   logic is_amp;

   assign is_ok  = allowed_byte(data_byte);
   assign is_eq  = (data_byte == ChEquals);
   assign is_amp = (data_byte == ChAmp);

   always_comb begin
      state_nxt         = state_cur;
      result.role       = ROLE_IGNORED;
      result.pair_done  = 1'b0;
      result.error_code = ERR_NONE;
      unique case (state_cur.phase)
         PH_NAME: begin
            if (is_eq) begin
               result.role = ROLE_EQUALS;
               if (!state_cur.name_started) begin
                  result.error_code = ERR_EMPTY_NAME;
               end else if (state_cur.name_bad) begin
                  result.error_code = ERR_BAD_NAME;
               end else if (last_byte) begin
                  result.error_code = ERR_EMPTY_VALUE;
               end
               state_nxt.phase = (result.error_code != ERR_NONE) ? PH_ERROR : PH_VALUE;
            end else begin
               result.role            = ROLE_NAME;
               state_nxt.name_started = 1'b1;
               if (!is_ok) state_nxt.name_bad = 1'b1;
               if (last_byte) begin
                  result.error_code = ERR_NO_EQUALS;
                  state_nxt.phase   = PH_ERROR;
               end
            end
         end
         PH_VALUE: begin
            if (is_amp) begin
               result.role      = ROLE_AMP;
               result.pair_done = 1'b1;
               state_nxt        = '{phase: PH_NAME, name_started: 1'b0, name_bad: 1'b0};
            end else begin
               result.role = ROLE_VALUE;
               if (!is_ok) begin
                  result.error_code = ERR_BAD_VALUE;
                  state_nxt.phase   = PH_ERROR;
               end else if (last_byte) begin
                  result.pair_done = 1'b1;
               end
            end
         end
         default: ;  // error phase, and the unused code: ignore the byte
      endcase
      // body over: start fresh for the next one
      if (last_byte) begin
         state_nxt = '{phase: PH_NAME, name_started: 1'b0, name_bad: 1'b0};
      end
   end

endmodule

### sv/fbt_checker.sv
// Port-level checks on the tokenizer result stream, bound to the top level.
// Depends on fbt_pkg for the role and error codes.
module fbt_checker import fbt_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_tvalid,
   input logic                 rsp_tready,
   input logic [ByteWidth-1:0] rsp_tdata,
   input logic [UserWidth-1:0] rsp_tuser,
   input logic                 rsp_tlast
);

   logic [RoleWidth-1:0] role;
   logic                 done;
   logic [ErrWidth-1:0]  err;

   assign role = rsp_tuser[RoleWidth-1:0];
   assign done = rsp_tuser[RoleWidth];
   assign err  = rsp_tuser[UserWidth-1:RoleWidth+1];

   // stalled word holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("rsp word changed while stalled");

   // a pair can only close on an ampersand or a value byte at body end
   a_done_role: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && done |-> role == ROLE_AMP || (role == ROLE_VALUE && rsp_tlast))
      else $error("pair_done on wrong byte");

   a_done_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && done |-> err == ERR_NONE)
      else $error("pair_done together with an error");

   // ignored bytes carry nothing
   a_ignored: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && role == ROLE_IGNORED |-> err == ERR_NONE && !done)
      else $error("ignored byte carries a flag");

   // missing equals only at body end on a name byte
   a_no_eq: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && err == ERR_NO_EQUALS |-> rsp_tlast && role == ROLE_NAME)
      else $error("missing equals outside body end");

endmodule

bind form_body_tokenizer_unit fbt_checker u_fbt_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
